### rtl/core/rrcs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrcs_pkg
// Shared widths and constants for the row run centre-line selector.
// ----------------------------------------------------------------------------
package rrcs_pkg;

	localparam int MAX_COLUMNS = 512;
	localparam int COL_W       = $clog2(MAX_COLUMNS);
	localparam int WID_W       = COL_W + 1;
	// 5*width needs two bits over the width, plus a sign bit
	localparam int SCORE_W     = WID_W + 3;
	localparam int CFG_W       = 10;

	localparam logic [CFG_W-1:0] MIN_WIDTH_RST = CFG_W'(1);
	localparam logic [COL_W-1:0] LAST_COL      = COL_W'(MAX_COLUMNS - 1);

	// Output tdata layout: centre column first, then run width, padded to bytes
	localparam int OUT_DATA_W = ((COL_W + WID_W + 7) / 8) * 8;

	typedef logic [COL_W-1:0]          col_t;
	typedef logic [WID_W-1:0]          wid_t;
	typedef logic signed [SCORE_W-1:0] score_t;

endpackage : rrcs_pkg
`default_nettype wire

### rtl/core/row_run_centerline_select_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// row_run_centerline_select_top
// Per-row choice of one surface run in a binary mask, raster order.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_axis carries one mask pixel per word: tdata[0] is the
//   pixel, tlast marks the last pixel of a row and tuser flags the first
//   pixel of a frame. Master stream m_axis carries one word per row:
//   tuser says whether a run was chosen, tdata holds its centre column and
//   width (both zero when nothing qualified).
//   min_width_px is written through cfg_we/cfg_wdata while the block is idle.
// Path: a row-ending pixel is registered at the input, scored from that register
//   once the result register is free, and its result word is loaded into the
//   result register, which drives m_axis.
// Throughput: one pixel per clock unless a row end waits on a pending word. The
//   scoring path (width, centre, distance to the previous centre, compare with
//   the row's best) sits between the input register and the state/result registers.
// Reset: arst_n clears the column count, any open run, the row's best choice,
//   the remembered centre and every valid flag; min_width_px returns to 1.
// Stall: while a result word waits on m_axis, non-ending pixels keep flowing;
//   only a further row-ending pixel waits in the input register until the
//   receiver takes the pending word.
// ----------------------------------------------------------------------------
module row_run_centerline_select_top
	import rrcs_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration
	input  wire logic                  cfg_we,
	input  wire logic [CFG_W-1:0]      cfg_wdata,    // min_width_px
	// pixel stream
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [7:0]            s_axis_tdata, // [0] pixel_set, rest zero
	input  wire logic                  s_axis_tlast, // row_end
	input  wire logic                  s_axis_tuser, // [0] frame_start
	// row result stream
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0]      m_axis_tdata, // [8:0] centre column,
	                                                 // [18:9] run_width, rest zero
	output logic                       m_axis_tuser  // [0] row_found
);

	// Input stage
	logic valid_s1;
	logic pix_s1, rend_s1, fstart_s1;

	// Row state
	logic [CFG_W-1:0] min_width_q;
	col_t             col_q;
	logic             in_run_q;
	col_t             run_start_q;
	logic             best_valid_q;
	score_t           best_score_q;
	col_t             best_center_q;
	wid_t             best_width_q;
	logic             prev_valid_q;
	col_t             prev_center_q;

	// Result register
	logic out_valid_q;
	logic out_found_q;
	col_t out_center_q;
	wid_t out_width_q;

	// Effective state once a frame start has been applied
	col_t cur_col;
	logic cur_in_run, cur_best_valid, cur_prev_valid;
	logic last;

	// Candidate run
	logic                cand_valid;
	col_t                run_s, run_e;
	wid_t                cand_w;
	logic [COL_W:0]      sum_se;
	col_t                cand_c;
	col_t                ctr_gap;
	score_t              cand_score;
	logic                keep, take;

	// Row best after this pixel
	logic   nb_valid;
	score_t nb_score;
	col_t   nb_center;
	wid_t   nb_width;

	logic out_free, adv;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign adv           = valid_s1 && (!last || out_free);
	assign s_axis_tready = !valid_s1 || adv;

	always_comb begin
		cur_col        = fstart_s1 ? '0 : col_q;
		cur_in_run     = fstart_s1 ? 1'b0 : in_run_q;
		cur_best_valid = fstart_s1 ? 1'b0 : best_valid_q;
		cur_prev_valid = fstart_s1 ? 1'b0 : prev_valid_q;
		// A full-width row closes on its last column even without tlast
		last           = rend_s1 || (cur_col == LAST_COL);
	end

	// At most one run closes per pixel: a clear pixel ends the open run one
	// column back, a set pixel on the row end closes its run here.
	always_comb begin
		cand_valid = 1'b0;
		run_s      = run_start_q;
		run_e      = cur_col;
		if (cur_in_run && !pix_s1) begin
			cand_valid = 1'b1;
			run_e      = cur_col - COL_W'(1);
		end else if (pix_s1 && last) begin
			cand_valid = 1'b1;
			run_s      = cur_in_run ? run_start_q : cur_col;
		end
		cand_w     = {1'b0, run_e} - {1'b0, run_s} + WID_W'(1);
		sum_se     = {1'b0, run_s} + {1'b0, run_e} + (COL_W+1)'(1);
		cand_c     = sum_se[COL_W:1];
		ctr_gap    = (cand_c >= prev_center_q) ? (cand_c - prev_center_q)
		                                       : (prev_center_q - cand_c);
		// 5*width minus distance: the 0.2 weight on distance, scaled by 5
		cand_score = score_t'({cand_w, 2'b00}) + score_t'(cand_w)
		             - (cur_prev_valid ? score_t'(ctr_gap) : score_t'(0));
		keep       = cand_valid && ({1'b0, cand_w} >= {1'b0, min_width_q});
		take       = keep && (!cur_best_valid || (cand_score > best_score_q));
		nb_valid   = cur_best_valid || take;
		nb_score   = take ? cand_score : best_score_q;
		nb_center  = take ? cand_c : best_center_q;
		nb_width   = take ? cand_w : best_width_q;
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_width_q <= MIN_WIDTH_RST;
		end else if (cfg_we) begin
			min_width_q <= cfg_wdata;
		end
	end

	// Input stage: hold a word until it can be scored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			pix_s1    <= s_axis_tdata[0];
			rend_s1   <= s_axis_tlast;
			fstart_s1 <= s_axis_tuser;
		end
	end

	// Row state: advance on each scored pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q         <= '0;
			in_run_q      <= 1'b0;
			run_start_q   <= '0;
			best_valid_q  <= 1'b0;
			best_score_q  <= '0;
			best_center_q <= '0;
			best_width_q  <= '0;
			prev_valid_q  <= 1'b0;
			prev_center_q <= '0;
		end else if (adv) begin
			if (last) begin
				col_q         <= '0;
				in_run_q      <= 1'b0;
				best_valid_q  <= 1'b0;
				best_score_q  <= '0;
				best_center_q <= '0;
				best_width_q  <= '0;
				prev_valid_q  <= cur_prev_valid || nb_valid;
				if (nb_valid) begin
					prev_center_q <= nb_center;
				end
			end else begin
				col_q         <= cur_col + COL_W'(1);
				in_run_q      <= pix_s1;
				best_valid_q  <= nb_valid;
				best_score_q  <= nb_score;
				best_center_q <= nb_center;
				best_width_q  <= nb_width;
				prev_valid_q  <= cur_prev_valid;
			end
			if (pix_s1 && !cur_in_run) begin
				run_start_q <= cur_col;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last) begin
			out_found_q  <= nb_valid;
			out_center_q <= nb_valid ? nb_center : '0;
			out_width_q  <= nb_valid ? nb_width : '0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_found_q;
	assign m_axis_tdata  = OUT_DATA_W'({out_width_q, out_center_q});

	// ------------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------------
	a_mid_row_flows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !last |-> adv)
		else $error("mid-row pixel held in input stage");

	a_word_from_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(adv && last))
		else $error("result word without a row end");

	a_empty_row_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_found_q |-> (out_center_q == '0) && (out_width_q == '0))
		else $error("empty row carries nonzero data");

	a_best_has_width: assert property (@(posedge clk) disable iff (!arst_n)
		best_valid_q |-> (best_width_q != '0))
		else $error("chosen run of zero width");

endmodule : row_run_centerline_select_top
`default_nettype wire

### verif/row_choice_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// row_choice_checker
// Watches the pixel, row-word and min-width ports of the row run selector,
// predicts one word per row end and compares each delivered word with it.
// ----------------------------------------------------------------------------
module row_choice_checker
	import rrcs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_W-1:0]      cfg_wdata,      // min_width_px
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [7:0]            s_axis_tdata,   // [0] pixel_set, rest zero
	input  logic                  s_axis_tlast,   // row_end
	input  logic                  s_axis_tuser,   // [0] frame_start
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,   // [8:0] centre column,
	                                              // [18:9] run_width, rest zero
	input  logic                  m_axis_tuser,   // [0] row_found
	input  logic                  end_check,
	output int                    fail_count,
	output int                    rows_waiting
);

	typedef struct packed {
		logic found;
		col_t centre;
		wid_t width;
	} row_result_t;

	row_result_t expected_rows[$];

	// Mirror of the selector state
	logic [CFG_W-1:0] min_wid      = MIN_WIDTH_RST;
	col_t             col_cnt      = '0;
	bit               run_open     = 1'b0;
	col_t             run_first    = '0;
	bit               best_ok      = 1'b0;
	score_t           best_score   = '0;
	col_t             best_centre  = '0;
	wid_t             best_wid     = '0;
	bit               prev_ok      = 1'b0;
	col_t             prev_centre  = '0;

	int mismatches        = 0;
	int rows_checked      = 0;
	bit leftovers_checked = 1'b0;

	assign fail_count = mismatches;

	task automatic report_mismatch(input string what);
		if (mismatches < 40)
			$display("[%0t] row %0d: %s", $time, rows_checked, what);
		mismatches++;
	endtask

	task automatic clear_state();
		expected_rows.delete();
		min_wid     = MIN_WIDTH_RST;
		col_cnt     = '0;
		run_open    = 1'b0;
		run_first   = '0;
		best_ok     = 1'b0;
		best_score  = '0;
		best_centre = '0;
		best_wid    = '0;
		prev_ok     = 1'b0;
		prev_centre = '0;
	endtask

	// Score one closed run and keep it if it beats the row's best so far
	task automatic weigh_run(input col_t first, input col_t last_col);
		int     fi;
		int     li;
		int     ci;
		int     pi;
		int     gap;
		wid_t   w;
		col_t   c;
		score_t s;
		fi = first;
		li = last_col;
		w  = wid_t'(li - fi + 1);
		if (w >= min_wid) begin
			c    = col_t'((fi + li + 1) >> 1);
			ci   = c;
			pi   = prev_centre;
			gap  = prev_ok ? ((ci >= pi) ? ci - pi : pi - ci) : 0;
			s    = score_t'(5 * int'(w) - gap);
			if (!best_ok || s > best_score) begin
				best_ok     = 1'b1;
				best_score  = s;
				best_centre = c;
				best_wid    = w;
			end
		end
	endtask

	task automatic take_pixel(input bit pix, input bit rend, input bit fstart);
		col_t        col;
		bit          row_done;
		row_result_t res;
		if (fstart) begin
			prev_ok  = 1'b0;
			run_open = 1'b0;
			best_ok  = 1'b0;
			col_cnt  = '0;
		end
		col      = col_cnt;
		row_done = rend || (col == LAST_COL);
		if (run_open && !pix) begin
			weigh_run(run_first, col - col_t'(1));
			run_open = 1'b0;
		end
		if (pix && !run_open) begin
			run_first = col;
			run_open  = 1'b1;
		end
		if (pix && row_done) begin
			weigh_run(run_first, col);
			run_open = 1'b0;
		end
		if (!row_done) begin
			col_cnt = col + col_t'(1);
		end else begin
			res.found  = best_ok;
			res.centre = best_ok ? best_centre : '0;
			res.width  = best_ok ? best_wid : '0;
			expected_rows = {expected_rows, res};
			if (best_ok) begin
				prev_ok     = 1'b1;
				prev_centre = best_centre;
			end
			best_ok     = 1'b0;
			best_score  = '0;
			best_centre = '0;
			best_wid    = '0;
			run_open    = 1'b0;
			col_cnt     = '0;
		end
	endtask

	task automatic check_word();
		row_result_t want;
		col_t        got_centre;
		wid_t        got_width;
		got_centre = m_axis_tdata[COL_W-1:0];
		got_width  = m_axis_tdata[COL_W+WID_W-1:COL_W];
		if (expected_rows.size() == 0) begin
			report_mismatch($sformatf("unexpected word: found %0b centre %0d width %0d",
				m_axis_tuser, got_centre, got_width));
		end else begin
			want = expected_rows.pop_front();
			if (m_axis_tuser !== want.found)
				report_mismatch($sformatf("row_found %0b, want %0b", m_axis_tuser, want.found));
			if (got_centre !== want.centre)
				report_mismatch($sformatf("centre column %0d, want %0d", got_centre,
					want.centre));
			if (got_width !== want.width)
				report_mismatch($sformatf("run_width %0d, want %0d", got_width, want.width));
		end
		rows_checked++;
	endtask

	// Outgoing words first, so a word can never match a pixel taken on the same edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_state();
			rows_waiting <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				check_word();
			if (cfg_we)
				min_wid = cfg_wdata;
			if (s_axis_tvalid && s_axis_tready)
				take_pixel(s_axis_tdata[0], s_axis_tlast, s_axis_tuser);
			if (end_check && !leftovers_checked) begin
				leftovers_checked = 1'b1;
				if (expected_rows.size() != 0)
					report_mismatch($sformatf("%0d row words never arrived",
						expected_rows.size()));
			end
			rows_waiting <= expected_rows.size();
		end
	end

endmodule : row_choice_checker

### verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives mask pixels into the row run selector in frames of rows, with
// directed rows first and random frames after, under several minimum widths.
// The checker beside the block predicts and compares every row word; this
// module only makes traffic, throttles both streams and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
	import rrcs_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 120;  // long receiver hold-off
	localparam int DRAIN_SLACK = 6;    // two-stage pipeline plus margin

	typedef enum int {
		SHAPE_MIXED,   // random runs
		SHAPE_FULL,    // every pixel set
		SHAPE_TAIL     // only the last pixel set
	} row_shape_e;

	// Directed pixels, each {frame_start, row_end, pixel_set}
	localparam logic [2:0] DIRECTED_PIXELS [0:21] = '{
		// two runs, the wider one wins
		3'b101, 3'b001, 3'b000, 3'b001, 3'b001, 3'b001, 3'b010,
		// run still open on the row-ending pixel
		3'b000, 3'b001, 3'b001, 3'b001, 3'b011,
		// one-pixel rows, set and clear
		3'b011,
		3'b010,
		// frame start arriving mid-row
		3'b001, 3'b001, 3'b101, 3'b000, 3'b011,
		// equal scores with no previous centre: the first run must win
		3'b101, 3'b000, 3'b011
	};

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  cfg_we        = 1'b0;
	logic [CFG_W-1:0]      cfg_wdata     = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata  = '0;
	logic                  s_axis_tlast  = 1'b0;
	logic                  s_axis_tuser  = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tuser;
	logic                  end_check     = 1'b0;

	int fail_count;
	int rows_waiting;
	int cycle_count = 0;
	int pixels_sent = 0;

	bit src_idle_on  = 1'b1;
	bit sink_idle_on = 1'b1;
	bit quiet_tail   = 1'b0;
	bit hold_off_req = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	row_run_centerline_select_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	row_choice_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.end_check     (end_check),
		.fail_count    (fail_count),
		.rows_waiting  (rows_waiting)
	);

	// Offer one pixel word and hold it until the block takes it. A random idle
	// burst may come first; this task lowers valid only before such a burst, so
	// back-to-back words keep it high without a second assignment in the step.
	task automatic push_pixel(input bit pix, input bit rend, input bit fstart);
		if (src_idle_on && $urandom_range(0, 7) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'd0, pix};
		s_axis_tlast  <= rend;
		s_axis_tuser  <= fstart;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pixels_sent++;
	endtask

	// Send one row of len pixels with row_end on the last. Rows longer than
	// the block's column limit are cut by the block itself and the rest
	// carries on as a fresh row. Mixed rows now and then get a frame start
	// dropped into the middle.
	task automatic send_row(input row_shape_e shape, input int len, input bit fstart);
		bit pix;
		int flip_pct;
		int cut;
		flip_pct = $urandom_range(2, 50);
		pix      = $urandom_range(0, 1);
		cut      = -1;
		if (shape == SHAPE_MIXED && len > 1 && $urandom_range(0, 24) == 0)
			cut = $urandom_range(1, len - 1);
		for (int i = 0; i < len; i++) begin
			case (shape)
				SHAPE_FULL: begin
					pix = 1'b1;
				end
				SHAPE_TAIL: begin
					pix = (i == len - 1);
				end
				default: begin
					if ($urandom_range(1, 100) <= flip_pct)
						pix = !pix;
				end
			endcase
			push_pixel(pix, i == len - 1, (fstart && i == 0) || i == cut);
		end
	endtask

	// Frames of short random rows until budget more pixels have gone in
	task automatic send_frames(input int budget);
		int stop_at;
		int rows;
		stop_at = pixels_sent + budget;
		while (pixels_sent < stop_at) begin
			if (!quiet_tail) begin
				src_idle_on  = ($urandom_range(0, 3) != 0);
				sink_idle_on = ($urandom_range(0, 3) != 0);
			end
			rows = $urandom_range(1, 10);
			for (int r = 0; r < rows && pixels_sent < stop_at; r++)
				send_row(SHAPE_MIXED, $urandom_range(1, 40), r == 0);
		end
	endtask

	// Stop offering, wait for every predicted word, then let the pipeline settle
	task automatic wait_results_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (rows_waiting != 0);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	task automatic write_min_width(input logic [CFG_W-1:0] value);
		wait_results_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Receiver: ready stretches, random stall bursts and, on request, one long
	// hold-off counted here while the sender keeps pushing.
	initial begin : row_sink
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	// Give up on a hung block
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin : pixel_source
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows at the reset minimum width
		for (int i = 0; i < 22; i++)
			push_pixel(DIRECTED_PIXELS[i][0], DIRECTED_PIXELS[i][1], DIRECTED_PIXELS[i][2]);
		send_frames(60);

		// Zero minimum width keeps everything; a lone pixel at the last column
		// gives the highest centre
		write_min_width(10'd0);
		send_row(SHAPE_TAIL, 512, 1'b1);
		send_frames(30);

		// Hold the receiver off and keep pushing short rows so the block fills
		// and stalls its input, then pause until every word is home
		write_min_width(10'd3);
		hold_off_req = 1'b1;
		repeat (30) send_row(SHAPE_MIXED, $urandom_range(1, 2), 1'b0);
		wait_results_drained();
		send_frames(40);

		// Only a full row qualifies; 513 pixels overrun the column limit
		write_min_width(10'd512);
		send_row(SHAPE_FULL, 513, 1'b1);
		send_frames(20);

		// Wider than any row: nothing is ever found
		write_min_width(10'd1023);
		send_frames(30);

		write_min_width(CFG_W'($urandom_range(2, 24)));
		send_frames(40);

		// Back to the reset value, both sides flat out to the end
		write_min_width(MIN_WIDTH_RST);
		quiet_tail   = 1'b1;
		src_idle_on  = 1'b0;
		sink_idle_on = 1'b0;
		send_frames(40);

		wait_results_drained();
		end_check <= 1'b1;
		repeat (2) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule : testbench
